/* sv/projected_minmax_decimator_macros.svh */
// ----------------------------------------------------------------------------
// Projected min/max decimator assertion macros
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef PROJECTED_MINMAX_DECIMATOR_MACROS_SVH
`define PROJECTED_MINMAX_DECIMATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PMMD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pmmd check failed");

`define PMMD_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pmmd sequence check failed");

`else

`define PMMD_ASSERT(name, clk, rst_n, prop)

`define PMMD_ASSERT_NEXT(name, clk, rst_n, pre, post)

`endif

`endif

/* sv/pmmd_pkg.sv */
// ----------------------------------------------------------------------------
// Projected min/max decimator package
// Field widths, configuration layout, queue item and point kind codes.
// ----------------------------------------------------------------------------
package pmmd_pkg;

  localparam int MAX_GROUP = 1024;
  localparam int MAX_ROWS  = 4096;

  localparam int COEF_W     = 21;
  localparam int DIV_W      = 23;
  localparam int CENTER_W   = 15;
  localparam int SAMPLE_W   = 16;
  localparam int GROUP_W    = 11;
  localparam int ROW_W      = 13;
  localparam int VALUE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int GIDX_W = $clog2(MAX_GROUP);
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = COEF_W + DIFF_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int STEP_W = $clog2(MAG_W);
  localparam int SUM_W  = NUM_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A,
    REG_COEF_B,
    REG_DIVISOR_C,
    REG_CENTER,
    REG_AVG_X,
    REG_AVG_Y,
    REG_GROUP_SIZE,
    REG_ROW_COUNT
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_START,
    KIND_MIN,
    KIND_MAX,
    KIND_LAST,
    KIND_NEXT
  } point_kind_e;

  typedef struct packed {
    logic signed [COEF_W-1:0]   coef_a;
    logic signed [COEF_W-1:0]   coef_b;
    logic        [DIV_W-1:0]    divisor_c;
    logic        [CENTER_W-1:0] center;
    logic signed [SAMPLE_W-1:0] avg_x;
    logic signed [SAMPLE_W-1:0] avg_y;
    logic        [GROUP_W-1:0]  group_size;
    logic        [ROW_W-1:0]    row_count;
  } cfg_t;

  typedef struct packed {
    logic                      frame_start;
    logic signed [VALUE_W-1:0] value;
  } item_t;

endpackage

/* sv/pmmd_if.sv */
// ----------------------------------------------------------------------------
// Projected min/max decimator channel interfaces
// Valid/ready channels for input samples and emitted trace points.
// ----------------------------------------------------------------------------
interface pmmd_sample_if import pmmd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;
  logic                       in_range;
  logic                       frame_start;

  modport source (output valid, sample_x, sample_y, in_range, frame_start, input ready);
  modport sink   (input valid, sample_x, sample_y, in_range, frame_start, output ready);
endinterface

interface pmmd_point_if import pmmd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [ROW_W-1:0]   row;
  logic signed [VALUE_W-1:0] x_value;
  point_kind_e               point_kind;
  logic                      last_of_run;
  logic                      trace_done;

  modport source (output valid, row, x_value, point_kind, last_of_run, trace_done,
                  input ready);
  modport sink   (input valid, row, x_value, point_kind, last_of_run, trace_done,
                  output ready);
endinterface

/* sv/projected_minmax_decimator.sv */
// ----------------------------------------------------------------------------
// Projected min/max decimator
// Flow: an in-range sample passes multiply, sum, a 38-step divider and a
// saturation state before it reaches the queue; an out-of-range one goes
// straight to the push state. A new sample is taken only once the last is
// queued, and a closed row emits four points through the output register.
// Reset: registers return to defaults, queue empties, trace waits for a start.
// ----------------------------------------------------------------------------
module projected_minmax_decimator import pmmd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pmmd_sample_if.sink           sample_i,
  pmmd_point_if.source          point_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  push, full, pop, empty;
  item_t push_item, head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_a     <= '0;
      cfg_q.coef_b     <= COEF_W'(1);
      cfg_q.divisor_c  <= DIV_W'(1);
      cfg_q.center     <= '0;
      cfg_q.avg_x      <= '0;
      cfg_q.avg_y      <= '0;
      cfg_q.group_size <= GROUP_W'(1);
      cfg_q.row_count  <= ROW_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_COEF_A:     cfg_q.coef_a     <= cfg_data_i[COEF_W-1:0];
        REG_COEF_B:     cfg_q.coef_b     <= cfg_data_i[COEF_W-1:0];
        REG_DIVISOR_C:  cfg_q.divisor_c  <= cfg_data_i[DIV_W-1:0];
        REG_CENTER:     cfg_q.center     <= cfg_data_i[CENTER_W-1:0];
        REG_AVG_X:      cfg_q.avg_x      <= cfg_data_i[SAMPLE_W-1:0];
        REG_AVG_Y:      cfg_q.avg_y      <= cfg_data_i[SAMPLE_W-1:0];
        REG_GROUP_SIZE: cfg_q.group_size <= cfg_data_i[GROUP_W-1:0];
        REG_ROW_COUNT:  cfg_q.row_count  <= cfg_data_i[ROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pmmd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .sample_i (sample_i),
    .full_i   (full),
    .push_o   (push),
    .item_o   (push_item)
  );

  pmmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty)
  );

  pmmd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .item_i  (head_item),
    .pop_o   (pop),
    .point_o (point_o)
  );

endmodule

/* sv/pmmd_front.sv */
// ----------------------------------------------------------------------------
// Projected min/max decimator front end
// Accepts samples; projects in-range ones by multiply, sum and restoring
// divider, saturates, and queues the result, or the center if out of range.
// ----------------------------------------------------------------------------
`include "projected_minmax_decimator_macros.svh"

module pmmd_front import pmmd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  pmmd_sample_if.sink   sample_i,
  input  logic          full_i,
  output logic          push_o,
  output item_t         item_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_PUSH = 3'd5;

  logic [2:0]                state_q, state_d;
  logic signed [DIFF_W-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic signed [PROD_W-1:0]  pa_q, pa_d, pb_q, pb_d;
  logic                      frame_q, frame_d;
  logic                      neg_q, neg_d;
  logic [MAG_W-1:0]          quo_q, quo_d;
  logic [DIV_W-1:0]          rem_q, rem_d;
  logic [STEP_W-1:0]         step_q, step_d;
  logic signed [VALUE_W-1:0] value_q, value_d;

  logic                      accept;
  logic signed [NUM_W-1:0]   num, mag_full, quo_signed;
  logic [DIV_W-1:0]          dvs;
  logic [DIV_W:0]            trial, diff;
  logic                      ge;
  logic signed [SUM_W-1:0]   sum;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign accept         = sample_i.valid && sample_i.ready;
  assign push_o         = (state_q == ST_PUSH) && !full_i;
  assign item_o.frame_start = frame_q;
  assign item_o.value       = value_q;

  assign dvs   = (cfg_i.divisor_c == '0) ? DIV_W'(1) : cfg_i.divisor_c;
  assign trial = {rem_q, quo_q[MAG_W-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  assign num        = {pa_q[PROD_W-1], pa_q} + {pb_q[PROD_W-1], pb_q};
  assign mag_full   = num[NUM_W-1] ? -num : num;
  assign quo_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign sum        = $signed({quo_signed[NUM_W-1], quo_signed})
                    + $signed({{(SUM_W-CENTER_W){1'b0}}, cfg_i.center});

  always_comb begin
    state_d = state_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    frame_d = frame_q;
    neg_d   = neg_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    step_d  = step_q;
    value_d = value_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          dx_d    = $signed({sample_i.sample_x[SAMPLE_W-1], sample_i.sample_x})
                  - $signed({cfg_i.avg_x[SAMPLE_W-1], cfg_i.avg_x});
          dy_d    = $signed({sample_i.sample_y[SAMPLE_W-1], sample_i.sample_y})
                  - $signed({cfg_i.avg_y[SAMPLE_W-1], cfg_i.avg_y});
          frame_d = sample_i.frame_start;
          if (sample_i.in_range) begin
            state_d = ST_MUL;
          end else begin
            value_d = $signed({{(VALUE_W-CENTER_W){1'b0}}, cfg_i.center});
            state_d = ST_PUSH;
          end
        end
      end
      ST_MUL: begin
        pa_d    = cfg_i.coef_a * dx_q;
        pb_d    = cfg_i.coef_b * dy_q;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        neg_d   = num[NUM_W-1];
        quo_d   = mag_full[MAG_W-1:0];
        rem_d   = '0;
        step_d  = STEP_W'(MAG_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], ge};
        if (step_q == '0) begin
          state_d = ST_FIN;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_FIN: begin
        if ((sum[SUM_W-1:VALUE_W-1] == '0) || (sum[SUM_W-1:VALUE_W-1] == '1)) begin
          value_d = sum[VALUE_W-1:0];
        end else if (sum[SUM_W-1]) begin
          value_d = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
          value_d = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (push_o) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    frame_q <= frame_d;
    neg_q   <= neg_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    value_q <= value_d;
  end

  `PMMD_ASSERT_NEXT(a_skip_divider, clk_i, rst_ni, accept && !sample_i.in_range, state_q == ST_PUSH)
  `PMMD_ASSERT_NEXT(a_div_ends, clk_i, rst_ni, state_q == ST_DIV && step_q == '0, state_q == ST_FIN)

endmodule

/* sv/pmmd_queue.sv */
// ----------------------------------------------------------------------------
// Projected min/max decimator item queue
// Short FIFO of projected items between the front end and the back end.
// ----------------------------------------------------------------------------
`include "projected_minmax_decimator_macros.svh"

module pmmd_queue import pmmd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  item_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;

  assign full_o  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `PMMD_ASSERT(a_no_overflow, clk_i, rst_ni, push_i |-> !full_o)
  `PMMD_ASSERT(a_no_underflow, clk_i, rst_ni, pop_i |-> !empty_o)

endmodule

/* sv/pmmd_back.sv */
// ----------------------------------------------------------------------------
// Projected min/max decimator back end
// Tracks row minimum, maximum and last value and emits the start point and
// the four points that close each row through an output register.
// ----------------------------------------------------------------------------
module pmmd_back import pmmd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          empty_i,
  input  item_t         item_i,
  output logic          pop_o,
  pmmd_point_if.source  point_o
);

  localparam logic ST_TAKE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                      state_q, state_d;
  logic [GIDX_W-1:0]         group_q, group_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic signed [VALUE_W-1:0] min_q, min_d, max_q, max_d, last_q, last_d, hold_q, hold_d;
  logic                      done_q, done_d;
  point_kind_e               kind_q, kind_d;

  logic                      out_valid_q, out_valid_d;
  logic [ROW_W-1:0]          out_row_q, out_row_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;
  point_kind_e               out_kind_q, out_kind_d;
  logic                      out_last_q, out_last_d;
  logic                      out_done_q, out_done_d;

  logic [GROUP_W-1:0]        scale;
  logic [ROW_W-1:0]          rows;
  logic                      fin, load_ok, in_group;

  always_comb begin
    if (cfg_i.group_size == '0) begin
      scale = GROUP_W'(1);
    end else if (cfg_i.group_size > GROUP_W'(MAX_GROUP)) begin
      scale = GROUP_W'(MAX_GROUP);
    end else begin
      scale = cfg_i.group_size;
    end
    if (cfg_i.row_count == '0) begin
      rows = ROW_W'(1);
    end else if (cfg_i.row_count > ROW_W'(MAX_ROWS)) begin
      rows = ROW_W'(MAX_ROWS);
    end else begin
      rows = cfg_i.row_count;
    end
  end

  assign fin      = (({1'b0, row_q} + 1'b1) >= {1'b0, rows});
  assign in_group = ((GROUP_W'(group_q) + 1'b1) < scale);
  assign load_ok  = !out_valid_q || point_o.ready;
  assign pop_o    = (state_q == ST_TAKE) && !empty_i;

  assign point_o.valid       = out_valid_q;
  assign point_o.row         = out_row_q;
  assign point_o.x_value     = out_value_q;
  assign point_o.point_kind  = out_kind_q;
  assign point_o.last_of_run = out_last_q;
  assign point_o.trace_done  = out_done_q;

  always_comb begin
    state_d     = state_q;
    group_d     = group_q;
    row_d       = row_q;
    min_d       = min_q;
    max_d       = max_q;
    last_d      = last_q;
    hold_d      = hold_q;
    done_d      = done_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q && !point_o.ready;
    out_row_d   = out_row_q;
    out_value_d = out_value_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    unique case (state_q)
      ST_TAKE: begin
        if (pop_o) begin
          if (item_i.frame_start) begin
            hold_d  = item_i.value;
            kind_d  = KIND_START;
            state_d = ST_EMIT;
          end else if (!done_q) begin
            if (in_group) begin
              last_d  = item_i.value;
              min_d   = (item_i.value < min_q) ? item_i.value : min_q;
              max_d   = (item_i.value > max_q) ? item_i.value : max_q;
              group_d = group_q + 1'b1;
            end else begin
              hold_d  = item_i.value;
              kind_d  = KIND_MIN;
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_row_d   = row_q;
          out_done_d  = fin;
          out_last_d  = 1'b0;
          case (kind_q)
            KIND_START: begin
              out_row_d   = '0;
              out_value_d = hold_q;
              out_done_d  = 1'b0;
              out_last_d  = 1'b1;
            end
            KIND_MIN: begin
              out_value_d = min_q;
              kind_d      = KIND_MAX;
            end
            KIND_MAX: begin
              out_value_d = max_q;
              kind_d      = KIND_LAST;
            end
            KIND_LAST: begin
              out_value_d = last_q;
              kind_d      = KIND_NEXT;
            end
            default: begin
              out_row_d   = row_q + 1'b1;
              out_value_d = hold_q;
              out_last_d  = 1'b1;
            end
          endcase
          if (kind_q == KIND_START || kind_q == KIND_NEXT) begin
            min_d   = hold_q;
            max_d   = hold_q;
            last_d  = hold_q;
            group_d = '0;
            state_d = ST_TAKE;
            if (kind_q == KIND_START) begin
              row_d  = '0;
              done_d = 1'b0;
            end else begin
              row_d  = row_q + 1'b1;
              done_d = fin;
            end
          end
        end
      end
      default: begin
        state_d = ST_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_TAKE;
      group_q     <= '0;
      row_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      last_q      <= '0;
      done_q      <= 1'b1;
      kind_q      <= KIND_START;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      group_q     <= group_d;
      row_q       <= row_d;
      min_q       <= min_d;
      max_q       <= max_d;
      last_q      <= last_d;
      done_q      <= done_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q      <= hold_d;
    out_row_q   <= out_row_d;
    out_value_q <= out_value_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Projected min/max decimator testbench
// Drives directed and random sample streams under several register settings,
// predicts every emitted trace point and compares field by field, with random
// stalls on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import pmmd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RANDOM_ITEMS   = 50;
  localparam int     CLAMP_ITEMS    = 12;
  localparam int     SETTLE_CYCLES  = 64;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     REPORT_LIMIT   = 10;
  localparam longint VALUE_MAX      = 64'sd2147483647;
  localparam longint VALUE_MIN      = -VALUE_MAX - 1;

  typedef struct {
    logic [ROW_W-1:0]          row;
    logic signed [VALUE_W-1:0] value;
    point_kind_e               kind;
    logic                      last;
    logic                      done;
  } trace_point_t;

  typedef struct {
    int     setup;
    int     x;
    int     y;
    int     rng;
    int     fs;
    int     pinned;
    longint pin_value;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  pmmd_sample_if sample_bus ();
  pmmd_point_if  point_bus ();

  projected_minmax_decimator u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .sample_i   (sample_bus),
    .point_o    (point_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  cfg_t cfg_sh = '{21'sd0, 21'sd1, 23'd1, 15'd0, 16'sd0, 16'sd0, 11'd1, 13'd1};
  int     grp_idx    = 0;
  int     row_idx    = 0;
  longint row_min    = 0;
  longint row_max    = 0;
  longint row_last   = 0;
  bit     trace_idle = 1'b1;

  trace_point_t pending_points[$];
  int folded_items   = 0;
  int mismatch_count = 0;
  int tx_gap         = 0;
  bit tx_calm        = 1'b0;
  bit rx_calm        = 1'b0;
  bit hold_req       = 1'b0;

  cfg_t dir_cfgs [3] = '{
    '{21'sd1048575, 21'sd1048575, 23'd0, 15'd32767, 16'sh8000, 16'sh8000, 11'd0, 13'd0},
    '{-21'sd1048575, -21'sd1048575, 23'd1, 15'd0, 16'sh8000, 16'sh8000, 11'd3, 13'd2},
    '{-21'sd1048575, 21'sd0, 23'd8388607, 15'd0, 16'sh8000, 16'sd0, 11'd2, 13'd4096}
  };

  dir_row_t dir_rows [] = '{
    '{-1,      5,      5, 1, 0, 0, 0},
    '{-1,      0,  32767, 1, 1, 1, 32767},
    '{-1,      0, -32768, 1, 0, 0, 0},
    '{-1,      7,      7, 1, 0, 0, 0},
    '{-1,      7,      7, 0, 1, 1, 0},
    '{ 0,  32767,  32767, 1, 1, 1, VALUE_MAX},
    '{-1, -32768, -32768, 1, 0, 1, VALUE_MAX},
    '{-1,      1,      1, 0, 0, 0, 0},
    '{ 1,  32767,  32767, 1, 1, 1, VALUE_MIN},
    '{-1,      0,      0, 0, 0, 0, 0},
    '{-1, -32768,  32767, 1, 0, 0, 0},
    '{-1, -32768, -32768, 1, 0, 1, VALUE_MIN},
    '{-1,    100,   -100, 1, 0, 0, 0},
    '{-1, -32768, -32768, 0, 0, 0, 0},
    '{-1,  32767, -32768, 1, 0, 0, 0},
    '{-1,      3,      3, 1, 0, 0, 0},
    '{ 2,  32767,      0, 1, 1, 0, 0},
    '{-1, -32768,  12345, 1, 0, 0, 0},
    '{-1, -32767,      0, 1, 0, 0, 0},
    '{-1,  32767,  32767, 1, 0, 0, 0},
    '{-1,      0,      0, 0, 1, 1, 0},
    '{-1,  32767,     -1, 1, 0, 0, 0},
    '{-1,      1,      1, 1, 0, 0, 0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_count(int v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return SAMPLE_W'(int'($urandom_range(0, 100)) - 50);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return 21'sd1048575;
      1:       return -21'sd1048575;
      2:       return '0;
      3:       return COEF_W'(int'($urandom_range(0, 600)) - 300);
      default: return COEF_W'(int'($urandom_range(0, 2097150)) - 1048575);
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.coef_a = pick_coef();
    c.coef_b = pick_coef();
    case ($urandom_range(0, 7))
      0:       c.divisor_c = '0;
      1:       c.divisor_c = 23'd1;
      2:       c.divisor_c = 23'd8388607;
      3:       c.divisor_c = DIV_W'($urandom_range(1, 100));
      default: c.divisor_c = DIV_W'($urandom_range(1, 8388607));
    endcase
    c.center     = ($urandom_range(0, 5) == 0) ? 15'h7fff : 15'($urandom_range(0, 32767));
    c.avg_x      = pick_coord();
    c.avg_y      = pick_coord();
    c.group_size = GROUP_W'($urandom_range(0, 4));
    c.row_count  = ROW_W'($urandom_range(0, 4));
    return c;
  endfunction

  function automatic longint project_sample(logic signed [SAMPLE_W-1:0] x,
                                            logic signed [SAMPLE_W-1:0] y, bit rng);
    longint num, div, pos;
    if (!rng) return longint'(cfg_sh.center);
    num = longint'($signed(cfg_sh.coef_a)) * (longint'(x) - longint'($signed(cfg_sh.avg_x)))
        + longint'($signed(cfg_sh.coef_b)) * (longint'(y) - longint'($signed(cfg_sh.avg_y)));
    div = (cfg_sh.divisor_c == '0) ? 64'sd1 : longint'(cfg_sh.divisor_c);
    pos = longint'(cfg_sh.center) + num / div;
    if (pos > VALUE_MAX) pos = VALUE_MAX;
    if (pos < VALUE_MIN) pos = VALUE_MIN;
    return pos;
  endfunction

  function automatic void push_point(int row, longint value, point_kind_e kind,
                                     bit last, bit done);
    trace_point_t pt;
    pt.row   = ROW_W'(row);
    pt.value = VALUE_W'(value);
    pt.kind  = kind;
    pt.last  = last;
    pt.done  = done;
    pending_points.insert(pending_points.size(), pt);
  endfunction

  function automatic int fold_sample(logic signed [SAMPLE_W-1:0] x,
                                     logic signed [SAMPLE_W-1:0] y, bit rng, bit fs);
    longint p;
    int     scale, rows;
    bit     fin;
    p     = project_sample(x, y, rng);
    scale = clamp_count(int'(cfg_sh.group_size), MAX_GROUP);
    rows  = clamp_count(int'(cfg_sh.row_count), MAX_ROWS);
    if (fs || !trace_idle) folded_items++;
    if (fs) begin
      row_min    = p;
      row_max    = p;
      row_last   = p;
      grp_idx    = 0;
      row_idx    = 0;
      trace_idle = 1'b0;
      push_point(0, p, KIND_START, 1'b1, 1'b0);
      return 1;
    end
    if (trace_idle) return 0;
    if (grp_idx + 1 < scale) begin
      row_last = p;
      if (p < row_min) row_min = p;
      if (p > row_max) row_max = p;
      grp_idx++;
      return 0;
    end
    fin = (row_idx + 1 >= rows);
    push_point(row_idx, row_min, KIND_MIN, 1'b0, fin);
    push_point(row_idx, row_max, KIND_MAX, 1'b0, fin);
    push_point(row_idx, row_last, KIND_LAST, 1'b0, fin);
    push_point(row_idx + 1, p, KIND_NEXT, 1'b1, fin);
    row_min  = p;
    row_max  = p;
    row_last = p;
    grp_idx  = 0;
    row_idx  = (row_idx + 1) & 32'h1fff;
    if (fin) trace_idle = 1'b1;
    return 4;
  endfunction

  function automatic void check_point();
    trace_point_t want;
    if (pending_points.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("unexpected point: row %0d value %0d kind %0d", point_bus.row,
                 point_bus.x_value, point_bus.point_kind);
      return;
    end
    want = pending_points.pop_front();
    if (want.row !== point_bus.row || want.value !== point_bus.x_value ||
        want.kind !== point_bus.point_kind || want.last !== point_bus.last_of_run ||
        want.done !== point_bus.trace_done) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("point mismatch: exp row %0d value %0d kind %0d last %0b done %0b,",
                 want.row, want.value, want.kind, want.last, want.done);
        $display("  got row %0d value %0d kind %0d last %0b done %0b",
                 point_bus.row, point_bus.x_value, point_bus.point_kind,
                 point_bus.last_of_run, point_bus.trace_done);
      end
    end
  endfunction

  task automatic apply_cfg(input cfg_t c);
    cfg_reg_e              r;
    logic [CFG_DATA_W-1:0] d;
    for (int i = 0; i < r.num(); i++) begin
      r = cfg_reg_e'(i);
      d = '0;
      case (r)
        REG_COEF_A:     d[COEF_W-1:0]   = c.coef_a;
        REG_COEF_B:     d[COEF_W-1:0]   = c.coef_b;
        REG_DIVISOR_C:  d[DIV_W-1:0]    = c.divisor_c;
        REG_CENTER:     d[CENTER_W-1:0] = c.center;
        REG_AVG_X:      d[SAMPLE_W-1:0] = c.avg_x;
        REG_AVG_Y:      d[SAMPLE_W-1:0] = c.avg_y;
        REG_GROUP_SIZE: d[GROUP_W-1:0]  = c.group_size;
        REG_ROW_COUNT:  d[ROW_W-1:0]    = c.row_count;
        default:        d = '0;
      endcase
      cfg_we   <= 1'b1;
      cfg_idx  <= r;
      cfg_data <= d;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_sh = c;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                             input logic signed [SAMPLE_W-1:0] y,
                             input bit rng, input bit fs, input bit pinned,
                             input longint pin_value);
    int produced;
    if (tx_gap > 0) repeat (tx_gap) @(posedge clk);
    sample_bus.valid       <= 1'b1;
    sample_bus.sample_x    <= x;
    sample_bus.sample_y    <= y;
    sample_bus.in_range    <= rng;
    sample_bus.frame_start <= fs;
    do @(posedge clk); while (!sample_bus.ready);
    produced = fold_sample(x, y, rng, fs);
    if (pinned && produced > 0)
      pending_points[pending_points.size() - produced].value = VALUE_W'(pin_value);
    tx_gap = pick_gap(tx_calm);
    if (tx_gap > 0) sample_bus.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    if (tx_gap == 0) sample_bus.valid <= 1'b0;
    tx_gap = 1;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : point_sink
    int stall_left;
    int rx_cycle;
    stall_left = 0;
    rx_cycle   = 0;
    point_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && point_bus.valid && point_bus.ready) check_point();
      rx_cycle++;
      if (rx_cycle % 150 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        point_bus.ready <= 1'b0;
      end else begin
        stall_left = pick_gap(rx_calm);
        point_bus.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && !(sample_bus.valid && sample_bus.ready) &&
          !(point_bus.valid && point_bus.ready))
        quiet++;
      else
        quiet = 0;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    cfg_t     c;
    dir_row_t r;
    int       base, n;
    bit       open;
    rst_n                  <= 1'b0;
    sample_bus.valid       <= 1'b0;
    sample_bus.sample_x    <= '0;
    sample_bus.sample_y    <= '0;
    sample_bus.in_range    <= 1'b0;
    sample_bus.frame_start <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_idx                <= REG_COEF_A;
    cfg_data               <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.setup >= 0) begin
        wait_idle();
        apply_cfg(dir_cfgs[r.setup]);
      end
      send_sample(SAMPLE_W'(r.x), SAMPLE_W'(r.y), r.rng != 0, r.fs != 0, r.pinned != 0,
                  r.pin_value);
    end

    base = folded_items;
    while (folded_items - base < RANDOM_ITEMS) begin
      wait_idle();
      c = random_cfg();
      apply_cfg(c);
      tx_calm = ($urandom_range(0, 3) == 0);
      n = clamp_count(int'(c.group_size), MAX_GROUP) * clamp_count(int'(c.row_count), MAX_ROWS)
        + 1 + $urandom_range(0, 2);
      open = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < n; k++)
        send_sample(pick_coord(), pick_coord(), $urandom_range(0, 3) != 0,
                    (k == 0 && open) || $urandom_range(0, 29) == 0, 1'b0, 64'sd0);
    end

    wait_idle();
    c = random_cfg();
    c.group_size = 11'd2047;
    c.row_count  = 13'd1;
    apply_cfg(c);
    tx_calm = 1'b0;
    for (int k = 0; k < CLAMP_ITEMS; k++)
      send_sample(pick_coord(), pick_coord(), $urandom_range(0, 15) == 0, k == 0, 1'b0,
                  64'sd0);

    wait_idle();
    c = random_cfg();
    c.group_size = 11'd1;
    c.row_count  = 13'd8191;
    apply_cfg(c);
    hold_req = 1'b1;
    for (int k = 0; k < CLAMP_ITEMS; k++)
      send_sample(pick_coord(), pick_coord(), $urandom_range(0, 31) == 0, k == 0, 1'b0,
                  64'sd0);

    wait_idle();
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* projected_minmax_decimator.f */
+incdir+sv
sv/pmmd_pkg.sv
sv/pmmd_if.sv
sv/pmmd_front.sv
sv/pmmd_queue.sv
sv/pmmd_back.sv
sv/projected_minmax_decimator.sv
test/testbench.sv
